// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== hw/rtl/bcd_acc_pkg.sv =====
// types, constants and helpers for the bcd accumulator
// no dependencies
package bcd_acc_pkg;

	localparam int NUM_DIGITS_DEF = 40;
	localparam logic [3:0] DIGIT_MAX = 4'd9;
	localparam logic [4:0] RADIX = 5'd10;
	localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;
	localparam int DIV10_SHIFT = 35;

	typedef enum logic [2:0] {
		KIND_FILL  = 3'd0,
		KIND_WRITE = 3'd1,
		KIND_ADD   = 3'd2,
		KIND_SUB   = 3'd3,
		KIND_READ  = 3'd4
	} kind_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [30:0] operand;
		logic [5:0]  index;
	} in_item_t;

	typedef struct packed {
		logic [3:0] digit;
		logic       last;
		logic       wrapped;
	} out_item_t;

	typedef struct packed {
		logic sub;
		logic cin;
	} alu_ctl_t;

	function automatic logic [3:0] clamp_digit(input logic [30:0] v);
		logic [3:0] d;
		d = (v > 31'(DIGIT_MAX)) ? DIGIT_MAX : v[3:0];
		return d;
	endfunction

endpackage

// ===== hw/rtl/bcd_acc_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module bcd_acc_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 40
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/bcd_acc_alu.sv =====
// shared digit unit: operand divide by ten and one bcd digit add or subtract
// depends on bcd_acc_pkg
module bcd_acc_alu (
	input  logic [30:0]          rest,
	input  logic [3:0]           a,
	input  logic [3:0]           od,
	input  bcd_acc_pkg::alu_ctl_t ctl,
	output logic [30:0]          quo,
	output logic [3:0]           rem,
	output logic [3:0]           res,
	output logic                 cout
);

	import bcd_acc_pkg::*;

	logic [62:0] prod;
	logic [33:0] quo10;
	logic [33:0] diff;
	logic [4:0]  sum5;
	logic [4:0]  need5;

	// reciprocal multiply, exact for any 31-bit value
	assign prod  = 63'(rest) * 63'(DIV10_MAGIC);
	assign quo   = 31'(prod[62:DIV10_SHIFT]);
	assign quo10 = ({3'b000, quo} << 3) + ({3'b000, quo} << 1);
	assign diff  = {3'b000, rest} - quo10;
	assign rem   = diff[3:0];

	assign sum5  = {1'b0, a} + {1'b0, od} + {4'b0000, ctl.cin};
	assign need5 = {1'b0, od} + {4'b0000, ctl.cin};

	always_comb begin
		res  = 4'd0;
		cout = 1'b0;
		if (!ctl.sub) begin
			if (sum5 > {1'b0, DIGIT_MAX}) begin
				res  = 4'(sum5 - RADIX);
				cout = 1'b1;
			end else begin
				res  = sum5[3:0];
			end
		end else begin
			if ({1'b0, a} < need5) begin
				res  = 4'({1'b0, a} + RADIX - need5);
				cout = 1'b1;
			end else begin
				res  = 4'({1'b0, a} - need5);
			end
		end
	end

endmodule

// ===== hw/rtl/bcd_accumulator_add_sub.sv =====
// top level of the decimal accumulator: sequencer, digit ram and valid bits
// depends on bcd_acc_pkg, bcd_acc_ram, bcd_acc_alu
//
// Holds a NUM_DIGITS-digit decimal number, position 0 most significant. A command
// transfers when start is high and busy is low; busy stays high until the command
// is finished. Add and subtract send every digit through one shared digit adder;
// all digits pass through one digit ram, one digit per cycle. Write digit and
// unused kinds give their single result in the next cycle. Fill writes one digit a
// cycle, and add and subtract start with a ram read lead-in, then go one digit a
// cycle from the least significant end, each with one result after the last digit.
// Read out starts with a ram read lead-in and gives NUM_DIGITS results, one per
// cycle, with last on the final one. Results carry a one-cycle strobe and cannot be
// held off. After reset the number reads as zero at once; no clearing pass is needed.
module bcd_accumulator_add_sub #(
	parameter int NUM_DIGITS = bcd_acc_pkg::NUM_DIGITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  bcd_acc_pkg::in_item_t  cmd,
	output logic                  strobe,
	output bcd_acc_pkg::out_item_t rsp
);

	import bcd_acc_pkg::*;

	localparam int AW = $clog2(NUM_DIGITS);
	localparam logic [AW-1:0] LAST = AW'(NUM_DIGITS - 1);
	localparam logic [6:0] NUM_W = 7'(NUM_DIGITS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_AR_PRE,
		ST_AR_RUN,
		ST_RD_PRE,
		ST_RD_RUN
	} state_t;

	state_t          state_q;
	logic [AW-1:0]   ptr_q;
	logic [30:0]     rest_q;
	logic [3:0]      od_q;
	logic            carry_q;
	logic            sub_q;
	logic [3:0]      fill_q;
	logic [NUM_DIGITS-1:0] vld_q;
	logic            rd_vld_q;
	logic            strobe_q;
	out_item_t       rsp_q;

	logic            accept;
	logic            we;
	logic [AW-1:0]   waddr;
	logic [3:0]      wdata;
	logic [AW-1:0]   raddr;
	logic [3:0]      ram_rdata;
	logic [3:0]      rdata;
	alu_ctl_t        alu_ctl;
	logic [30:0]     quo;
	logic [3:0]      rem;
	logic [3:0]      alu_res;
	logic            alu_cout;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign strobe = strobe_q;
	assign rsp    = rsp_q;
	assign rdata  = rd_vld_q ? ram_rdata : 4'd0;

	always_comb begin
		we    = 1'b0;
		waddr = ptr_q;
		wdata = alu_res;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (cmd.kind == KIND_WRITE) && ({1'b0, cmd.index} < NUM_W)) begin
					we    = 1'b1;
					waddr = cmd.index[AW-1:0];
					wdata = clamp_digit(cmd.operand);
				end
			end
			ST_FILL: begin
				we    = 1'b1;
				wdata = fill_q;
			end
			ST_AR_RUN: begin
				we    = 1'b1;
			end
			default: begin
				we    = 1'b0;
			end
		endcase
	end

	always_comb begin
		raddr = ptr_q;
		unique case (state_q)
			ST_AR_RUN: begin
				if (ptr_q != '0) begin
					raddr = ptr_q - AW'(1);
				end
			end
			ST_RD_RUN: begin
				if (ptr_q != LAST) begin
					raddr = ptr_q + AW'(1);
				end
			end
			default: begin
				raddr = ptr_q;
			end
		endcase
	end

	assign alu_ctl = '{sub: sub_q, cin: carry_q};

	bcd_acc_ram #(
		.WIDTH (4),
		.DEPTH (NUM_DIGITS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	bcd_acc_alu u_alu (
		.rest (rest_q),
		.a    (rdata),
		.od   (od_q),
		.ctl  (alu_ctl),
		.quo  (quo),
		.rem  (rem),
		.res  (alu_res),
		.cout (alu_cout)
	);

	// valid bit of the digit read, no reset needed
	always_ff @(posedge clk) begin
		rd_vld_q <= vld_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ptr_q    <= '0;
			vld_q    <= '0;
			strobe_q <= 1'b0;
			carry_q  <= 1'b0;
			sub_q    <= 1'b0;
			rest_q   <= '0;
			od_q     <= '0;
			fill_q   <= '0;
			rsp_q    <= '0;
		end else begin
			strobe_q <= 1'b0;
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (cmd.kind)
							KIND_FILL: begin
								fill_q  <= clamp_digit(cmd.operand);
								ptr_q   <= '0;
								state_q <= ST_FILL;
							end
							KIND_ADD, KIND_SUB: begin
								rest_q  <= cmd.operand;
								sub_q   <= (cmd.kind == KIND_SUB);
								carry_q <= 1'b0;
								ptr_q   <= LAST;
								state_q <= ST_AR_PRE;
							end
							KIND_READ: begin
								ptr_q   <= '0;
								state_q <= ST_RD_PRE;
							end
							default: begin
								strobe_q <= 1'b1;
								rsp_q    <= '{digit: 4'd0, last: 1'b1, wrapped: 1'b0};
							end
						endcase
					end
				end
				ST_FILL: begin
					if (ptr_q == LAST) begin
						strobe_q <= 1'b1;
						rsp_q    <= '{digit: 4'd0, last: 1'b1, wrapped: 1'b0};
						state_q  <= ST_IDLE;
					end else begin
						ptr_q <= ptr_q + AW'(1);
					end
				end
				ST_AR_PRE: begin
					od_q    <= rem;
					rest_q  <= quo;
					state_q <= ST_AR_RUN;
				end
				ST_AR_RUN: begin
					od_q    <= rem;
					rest_q  <= quo;
					carry_q <= alu_cout;
					if (ptr_q == '0) begin
						strobe_q <= 1'b1;
						rsp_q    <= '{digit: 4'd0, last: 1'b1,
							wrapped: alu_cout || (rest_q != '0)};
						state_q  <= ST_IDLE;
					end else begin
						ptr_q <= ptr_q - AW'(1);
					end
				end
				ST_RD_PRE: begin
					state_q <= ST_RD_RUN;
				end
				ST_RD_RUN: begin
					strobe_q <= 1'b1;
					rsp_q    <= '{digit: rdata, last: (ptr_q == LAST), wrapped: 1'b0};
					if (ptr_q == LAST) begin
						state_q <= ST_IDLE;
					end else begin
						ptr_q <= ptr_q + AW'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/bcd_acc_checker.sv =====
// port-level checks for the decimal accumulator, bound to the top level
// depends on bcd_acc_pkg, assert_macros.svh, bcd_accumulator_add_sub
`include "assert_macros.svh"

module bcd_acc_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   start,
	input logic                   busy,
	input bcd_acc_pkg::in_item_t  cmd,
	input logic                   strobe,
	input bcd_acc_pkg::out_item_t rsp
);

	import bcd_acc_pkg::*;

	// a digit write answers in the very next cycle
	`ASSERT_NEXT(a_write_resp, clk, arst_n, start && !busy && (cmd.kind == KIND_WRITE), strobe && rsp.last && !rsp.wrapped)

	// read out never answers in the cycle after the transfer
	`ASSERT_NEXT(a_read_lead, clk, arst_n, start && !busy && (cmd.kind == KIND_READ), busy && !strobe)

	// a result that is not the final one belongs to a running read out
	`ASSERT_IMPLIES(a_run_busy, clk, arst_n, strobe && !rsp.last, busy)

	`ASSERT_IMPLIES(a_digit_range, clk, arst_n, strobe, rsp.digit <= 4'd9)

	`ASSERT_IMPLIES(a_wrap_last, clk, arst_n, strobe && rsp.wrapped, rsp.last && (rsp.digit == 4'd0))

endmodule

bind bcd_accumulator_add_sub bcd_acc_checker u_chk (.*);

// ===== tb/bcd_accumulator_add_sub_tb.sv =====
// testbench for bcd_accumulator_add_sub: directed and random command streams
// checked against an in-bench model of the 40-digit decimal number
// depends on bcd_acc_pkg and the bcd_accumulator_add_sub rtl
module bcd_accumulator_add_sub_tb;
	import bcd_acc_pkg::*;

	localparam int N_DIG = NUM_DIGITS_DEF;
	localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
	localparam logic [2:0] KIND_SPARE_LAST = 3'd7;
	localparam logic [30:0] OPERAND_MAX = 31'h7FFF_FFFF;
	localparam logic [5:0] INDEX_MAX = 6'h3F;
	localparam int RANDOM_ITEMS = 105;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	in_item_t cmd = '0;
	logic strobe;
	out_item_t rsp;

	logic [3:0] acc_digits [N_DIG];
	out_item_t rsp_due [$];
	int n_err = 0;
	int burst_left = 0;
	int random_items = 0;

	bcd_accumulator_add_sub #(.NUM_DIGITS(N_DIG)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.strobe(strobe),
		.rsp(rsp)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

	function automatic logic [3:0] sat_digit(input logic [30:0] v);
		return (v > 31'd9) ? 4'd9 : v[3:0];
	endfunction

	// ripple from the least significant digit, returns carry or borrow out of the top
	function automatic logic ripple_digits(input logic [30:0] v, input logic sub);
		logic [30:0] rest;
		logic carry;
		int od;
		int s;
		rest = v;
		carry = 1'b0;
		for (int p = N_DIG - 1; p >= 0; p--) begin
			od = int'(rest % 31'd10);
			rest = rest / 31'd10;
			if (sub) begin
				s = int'(acc_digits[p]) - od - int'(carry);
				carry = (s < 0);
				if (s < 0) s += 10;
			end else begin
				s = int'(acc_digits[p]) + od + int'(carry);
				carry = (s > 9);
				if (s > 9) s -= 10;
			end
			acc_digits[p] = s[3:0];
		end
		if (rest != '0) carry = 1'b1;
		return carry;
	endfunction

	task automatic apply_cmd(input in_item_t c);
		logic wrap;
		wrap = 1'b0;
		case (c.kind)
			KIND_READ: begin
				for (int i = 0; i < N_DIG; i++)
					rsp_due.push_back('{digit: acc_digits[i], last: (i == N_DIG - 1), wrapped: 1'b0});
			end
			KIND_FILL: begin
				for (int i = 0; i < N_DIG; i++) acc_digits[i] = sat_digit(c.operand);
			end
			KIND_WRITE: begin
				if (c.index < N_DIG) acc_digits[c.index] = sat_digit(c.operand);
			end
			KIND_ADD: wrap = ripple_digits(c.operand, 1'b0);
			KIND_SUB: wrap = ripple_digits(c.operand, 1'b1);
			default: ;
		endcase
		if (c.kind != KIND_READ) rsp_due.push_back('{digit: 4'd0, last: 1'b1, wrapped: wrap});
	endtask

	task automatic note_error(input string msg);
		if (n_err < 10) $display("mismatch: %s", msg);
		n_err++;
	endtask

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (start && !busy) apply_cmd(cmd);
			if (strobe) begin
				if (rsp_due.size() == 0) begin
					note_error($sformatf("unexpected result digit=%0d last=%0b wrapped=%0b",
						rsp.digit, rsp.last, rsp.wrapped));
				end else begin
					want = rsp_due.pop_front();
					if (rsp !== want)
						note_error($sformatf("exp digit=%0d last=%0b wrapped=%0b, got digit=%0d last=%0b wrapped=%0b",
							want.digit, want.last, want.wrapped, rsp.digit, rsp.last, rsp.wrapped));
				end
			end
		end
	end

	// one command transfer, with random bursts and gaps on the start side
	task automatic send_item(input logic [2:0] k, input logic [30:0] op, input logic [5:0] idx);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		cmd <= '{kind: k, operand: op, index: idx};
		start <= 1'b1;
		do @(posedge clk); while (busy);
	endtask

	function automatic logic [30:0] rand_operand();
		case ($urandom_range(0, 3))
			0: return 31'($urandom_range(0, 9));
			1: return 31'($urandom_range(0, 99999));
			default: return 31'($urandom() >> 1);
		endcase
	endfunction

	task automatic test_fill_write();
		send_item(KIND_FILL, 31'd7, 6'd0);
		send_item(KIND_READ, 31'd0, 6'd0);
		send_item(KIND_FILL, OPERAND_MAX, INDEX_MAX);
		send_item(KIND_WRITE, 31'd0, 6'd0);
		send_item(KIND_WRITE, 31'd15, 6'(N_DIG - 1));
		send_item(KIND_WRITE, 31'd3, 6'(N_DIG));
		send_item(KIND_WRITE, 31'd5, INDEX_MAX);
		send_item(KIND_READ, OPERAND_MAX, INDEX_MAX);
	endtask

	task automatic test_carry_chain();
		send_item(KIND_FILL, 31'd0, 6'd0);
		send_item(KIND_ADD, OPERAND_MAX, 6'd0);
		send_item(KIND_ADD, OPERAND_MAX, 6'd0);
		send_item(KIND_SUB, 31'd1, 6'd0);
		send_item(KIND_SUB, 31'd0, 6'd0);
		send_item(KIND_READ, 31'd0, 6'd0);
	endtask

	task automatic test_wrap();
		send_item(KIND_FILL, 31'd9, 6'd0);
		send_item(KIND_ADD, 31'd1, 6'd0);
		send_item(KIND_READ, 31'd0, 6'd0);
		send_item(KIND_SUB, OPERAND_MAX, 6'd0);
		send_item(KIND_READ, 31'd0, 6'd0);
	endtask

	task automatic test_spare_kinds();
		for (int k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++)
			send_item(3'(k), rand_operand(), 6'($urandom_range(0, 63)));
		send_item(KIND_READ, 31'd0, 6'd0);
	endtask

	// random sequences: preload, tweak digits, run add/sub, read back, spare kinds
	task automatic test_random();
		logic [5:0] idx;
		logic [30:0] op;
		while (random_items < RANDOM_ITEMS) begin
			case ($urandom_range(0, 2))
				0: op = 31'd9;
				1: op = 31'd0;
				default: op = ($urandom_range(0, 4) == 0) ? rand_operand() : 31'($urandom_range(0, 9));
			endcase
			if ($urandom_range(0, 3) != 0) begin
				send_item(KIND_FILL, op, 6'($urandom_range(0, 63)));
				random_items++;
			end
			repeat ($urandom_range(0, 3)) begin
				idx = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(N_DIG, 63))
					: 6'($urandom_range(0, N_DIG - 1));
				op = ($urandom_range(0, 4) == 0) ? rand_operand() : 31'($urandom_range(0, 9));
				send_item(KIND_WRITE, op, idx);
				random_items++;
			end
			repeat ($urandom_range(1, 5)) begin
				send_item($urandom_range(0, 1) ? KIND_ADD : KIND_SUB, rand_operand(),
					6'($urandom_range(0, 63)));
				random_items++;
			end
			if ($urandom_range(0, 9) < 6) begin
				send_item(KIND_READ, rand_operand(), 6'($urandom_range(0, 63)));
				random_items++;
			end
			if ($urandom_range(0, 9) == 0)
				send_item(3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST)), rand_operand(),
					6'($urandom_range(0, 63)));
		end
	endtask

	initial begin
		for (int i = 0; i < N_DIG; i++) acc_digits[i] = 4'd0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fill_write();
		test_carry_chain();
		test_wrap();
		test_spare_kinds();
		test_random();
		start <= 1'b0;
		while (rsp_due.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (n_err == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/bcd_acc_pkg.sv
hw/rtl/bcd_acc_ram.sv
hw/rtl/bcd_acc_alu.sv
hw/rtl/bcd_accumulator_add_sub.sv
hw/rtl/bcd_acc_checker.sv
tb/bcd_accumulator_add_sub_tb.sv
